>>> sv/first_syn_source_filter_core_assert.svh
// ----------------------------------------------------------------------------
// first_syn_source_filter_core_assert.svh
// Assertion macros used by the checker file of the filter core.
// ----------------------------------------------------------------------------
`ifndef FIRST_SYN_SOURCE_FILTER_CORE_ASSERT_SVH
`define FIRST_SYN_SOURCE_FILTER_CORE_ASSERT_SVH

// Check a property on the rising clock edge, off while reset is held.
`define FSSF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on the rising clock edge.
`define FSSF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> sv/fssf_pkg.sv
// ----------------------------------------------------------------------------
// fssf_pkg
// Types and codes shared by the first-SYN source filter core and its cells.
// ----------------------------------------------------------------------------
package fssf_pkg;

    localparam logic [3:0] IPV4_VERSION = 4'd4;
    localparam logic [7:0] PROTO_TCP    = 8'd6;

    // Result status codes
    localparam logic [2:0] ST_NOT_TCP = 3'd0;
    localparam logic [2:0] ST_NOT_SYN = 3'd1;
    localparam logic [2:0] ST_SEEN    = 3'd2;
    localparam logic [2:0] ST_NEW     = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam int SLOT_W = 5;

    // Source pair used as the lookup key
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
    } key_t;

    // Search token control bits handed from cell to cell
    typedef struct packed {
        logic active;
        logic found;
        logic have_free;
    } tok_t;

endpackage

>>> sv/fssf_cell.sv
// ----------------------------------------------------------------------------
// fssf_cell
// One table slot: holds a source pair, checks the passing search token
// against it and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module fssf_cell #(
    parameter int IDX_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fssf_pkg::tok_t      in_ctl,
    input  fssf_pkg::key_t      in_key,
    input  logic [IDX_W-1:0]    in_found_idx,
    input  logic [IDX_W-1:0]    in_free_idx,
    output fssf_pkg::tok_t      out_ctl,
    output fssf_pkg::key_t      out_key,
    output logic [IDX_W-1:0]    out_found_idx,
    output logic [IDX_W-1:0]    out_free_idx,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_idx,
    input  fssf_pkg::key_t      wr_key
);
    import fssf_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic          valid_reg;
    key_t          entry_reg;
    tok_t          ctl_reg;
    tok_t          ctl_next;
    key_t          key_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic [IDX_W-1:0] found_idx_next;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] free_idx_next;
    logic          hit;
    logic          is_free;
    logic          wr_here;

    // Compare the token against this slot; keep the lowest match and free slot
    always_comb
    begin
        hit               = valid_reg && (entry_reg == in_key);
        is_free           = !valid_reg;
        ctl_next.active   = in_ctl.active;
        ctl_next.found    = in_ctl.found || hit;
        ctl_next.have_free = in_ctl.have_free || is_free;
        found_idx_next    = in_ctl.found ? in_found_idx : MY_IDX;
        free_idx_next     = in_ctl.have_free ? in_free_idx : MY_IDX;
        wr_here           = wr_en && (wr_idx == MY_IDX);
    end

    // Advance the token one cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= in_key;
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
    end

    // Store a new pair into this slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_here)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            entry_reg <= wr_key;
        end
    end

    assign out_ctl       = ctl_reg;
    assign out_key       = key_reg;
    assign out_found_idx = found_idx_reg;
    assign out_free_idx  = free_idx_reg;

endmodule

>>> sv/first_syn_source_filter_core.sv
// ----------------------------------------------------------------------------
// first_syn_source_filter_core
// Reports whether a pure TCP SYN comes from a source pair not seen before,
// storing new pairs into the lowest free table slot.
// ----------------------------------------------------------------------------
// The table is a row of TABLE_ENTRIES cells, one slot each. A pure IPv4 TCP
// SYN sends a search token down the row, one cell per cycle, collecting the
// first matching slot and the lowest free slot; the pair is written when the
// token leaves the last cell. One request is in work at a time: a pure SYN
// holds off the next acceptance until its token has walked the cell row and
// its result has moved into the output register, and any other header holds
// it off until its result has moved there. The result sits in an output
// register, so a new request is taken while an earlier result waits. Valid
// marks clear at reset; no clearing pass is needed.
module first_syn_source_filter_core #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ip_version[3:0], ip_protocol[11:4], tcp_header_ok[12], syn_flag[13],
    // ack_flag[14], source_address[46:15], source_port[62:47], zero[63]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // new_connection[0], status[3:1], slot[8:4], zero[15:9]
    output logic [15:0] m_tdata
);
    import fssf_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef struct packed {
        logic             new_connection;
        logic [2:0]       status;
        logic [SLOT_W-1:0] slot;
    } res_t;

    tok_t             ctl_w [TABLE_ENTRIES+1];
    key_t             key_w [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] fidx_w [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] free_w [TABLE_ENTRIES+1];

    tok_t  head_ctl_reg;
    tok_t  head_ctl_next;
    key_t  head_key_reg;
    logic  busy_reg;
    logic  busy_next;
    logic  pend_valid_reg;
    logic  pend_valid_next;
    res_t  pend_reg;
    res_t  pend_next;
    logic  out_valid_reg;
    logic  out_valid_next;
    res_t  out_reg;

    logic  accept;
    logic  is_tcp;
    logic  is_syn;
    key_t  in_key;
    tok_t  tail;
    res_t  tail_res;
    logic  out_load;
    logic  wr_en;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    // Decode the request
    always_comb
    begin
        accept      = s_tvalid && s_tready;
        is_tcp      = (s_tdata[3:0] == IPV4_VERSION) && (s_tdata[11:4] == PROTO_TCP) &&
                      s_tdata[12];
        is_syn      = s_tdata[13] && !s_tdata[14];
        in_key.addr = s_tdata[46:15];
        in_key.port = s_tdata[62:47];
    end

    // Launch the search token
    always_comb
    begin
        head_ctl_next           = '0;
        head_ctl_next.active    = accept && is_tcp && is_syn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ctl_reg <= '0;
        end
        else
        begin
            head_ctl_reg <= head_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_key_reg <= in_key;
        end
    end

    assign ctl_w[0]  = head_ctl_reg;
    assign key_w[0]  = head_key_reg;
    assign fidx_w[0] = '0;
    assign free_w[0] = '0;

    // Row of table cells
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        fssf_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .in_ctl        (ctl_w[i]),
            .in_key        (key_w[i]),
            .in_found_idx  (fidx_w[i]),
            .in_free_idx   (free_w[i]),
            .out_ctl       (ctl_w[i+1]),
            .out_key       (key_w[i+1]),
            .out_found_idx (fidx_w[i+1]),
            .out_free_idx  (free_w[i+1]),
            .wr_en         (wr_en),
            .wr_idx        (free_w[TABLE_ENTRIES]),
            .wr_key        (key_w[TABLE_ENTRIES])
        );
    end

    // Resolve the token leaving the last cell
    always_comb
    begin
        tail     = ctl_w[TABLE_ENTRIES];
        wr_en    = tail.active && !tail.found && tail.have_free;
        tail_res = '0;
        slot_ext = '0;
        if (tail.found)
        begin
            slot_ext        = {{SLOT_W{1'b0}}, fidx_w[TABLE_ENTRIES]};
            tail_res.status = ST_SEEN;
            tail_res.slot   = slot_ext[SLOT_W-1:0];
        end
        else if (tail.have_free)
        begin
            slot_ext                = {{SLOT_W{1'b0}}, free_w[TABLE_ENTRIES]};
            tail_res.new_connection = 1'b1;
            tail_res.status         = ST_NEW;
            tail_res.slot           = slot_ext[SLOT_W-1:0];
        end
        else
        begin
            tail_res.status = ST_FULL;
        end
    end

    // Track the request in work and the pending result
    always_comb
    begin
        out_load        = pend_valid_reg && (!out_valid_reg || m_tready);
        busy_next       = busy_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (accept && !is_tcp)
        begin
            pend_valid_next = 1'b1;
            pend_next       = '{new_connection: 1'b0, status: ST_NOT_TCP, slot: '0};
        end
        else if (accept && !is_syn)
        begin
            pend_valid_next = 1'b1;
            pend_next       = '{new_connection: 1'b0, status: ST_NOT_SYN, slot: '0};
        end
        else if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.active)
        begin
            busy_next       = 1'b0;
            pend_valid_next = 1'b1;
            pend_next       = tail_res;
        end
        else if (out_load)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (out_load)
        begin
            out_reg <= pend_reg;
        end
    end

    assign s_tready = !busy_reg && !pend_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.slot, out_reg.status, out_reg.new_connection};

endmodule

>>> sv/fssf_checker.sv
// ----------------------------------------------------------------------------
// fssf_checker
// Port-level checks of the first-SYN source filter core, bound to the top.
// ----------------------------------------------------------------------------
`include "first_syn_source_filter_core_assert.svh"

module fssf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import fssf_pkg::*;

    logic [2:0] res_status;
    logic [4:0] res_slot;
    logic       res_new;

    assign res_new    = m_tdata[0];
    assign res_status = m_tdata[3:1];
    assign res_slot   = m_tdata[8:4];

    // A stalled result holds
    `FSSF_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Only one request is in work at a time
    `FSSF_ASSERT(a_one_in_work, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "request taken while another is in work")

    // A new connection is flagged only with the stored-new status
    `FSSF_ASSERT(a_new_status, clk, rst_n, m_tvalid && res_new |-> res_status == ST_NEW, "new connection without stored status")

    // Only seen and stored results carry a slot
    `FSSF_ASSERT_NEVER(a_slot_zero, clk, rst_n, m_tvalid && res_status != ST_SEEN && res_status != ST_NEW && res_slot != 5'd0, "slot set on a result without one")

    // Status stays within its codes
    `FSSF_ASSERT_NEVER(a_status_code, clk, rst_n, m_tvalid && res_status > ST_FULL, "undefined status code")

endmodule

bind first_syn_source_filter_core fssf_checker u_fssf_checker (.*);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for first_syn_source_filter_core. A short table of header
// summaries probes the filtering rules and the table edges, then random
// requests drawn mostly from a small pool of source pairs fill the table,
// revisit stored pairs and run into the full case. Every result is compared
// against a verdict typed into the table or predicted by a behavioral model of the source table kept in the testbench.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fssf_pkg::*;

    localparam int TABLE_ENTRIES = 32;
    localparam int RANDOM_REQS   = 600;
    localparam int POOL_SIZE     = 40;

    // Header summary as packed into s_tdata, lowest field last
    typedef struct packed {
        logic [15:0] port;
        logic [31:0] addr;
        logic        ack;
        logic        syn;
        logic        hdr_ok;
        logic [7:0]  proto;
        logic [3:0]  version;
    } hdr_t;

    // Filter verdict as packed into m_tdata, lowest field last
    typedef struct packed {
        logic [4:0] slot;
        logic [2:0] status;
        logic       new_conn;
    } verdict_t;

    typedef struct {
        hdr_t     hdr;
        logic     typed;
        verdict_t verdict;
    } dir_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Disable random idling on both sides while set
    logic steady = 1'b0;

    // Model of the source table
    logic        pair_valid [TABLE_ENTRIES];
    logic [31:0] pair_addr  [TABLE_ENTRIES];
    logic [15:0] pair_port  [TABLE_ENTRIES];

    verdict_t verdict_q [$];
    dir_row_t dir_rows [$];
    logic [47:0] key_pool [POOL_SIZE];

    int n_reqs     = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_new      = 0;
    int n_seen     = 0;
    int n_full     = 0;
    int n_filtered = 0;

    first_syn_source_filter_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #1 clk = ~clk;

    // Classify one header and update the table model the way the block does
    function automatic verdict_t classify_syn(input hdr_t h);
        verdict_t v;
        int       free_idx;
        v = '0;
        v.status = ST_NOT_TCP;
        free_idx = -1;
        if (h.version != IPV4_VERSION || h.proto != PROTO_TCP || !h.hdr_ok)
            return v;
        if (!h.syn || h.ack) begin
            v.status = ST_NOT_SYN;
            return v;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!pair_valid[i]) begin
                if (free_idx < 0)
                    free_idx = i;
            end
            else if (pair_addr[i] == h.addr && pair_port[i] == h.port) begin
                v.status = ST_SEEN;
                v.slot   = i[4:0];
                return v;
            end
        end
        if (free_idx >= 0) begin
            pair_valid[free_idx] = 1'b1;
            pair_addr[free_idx]  = h.addr;
            pair_port[free_idx]  = h.port;
            v.new_conn = 1'b1;
            v.status   = ST_NEW;
            v.slot     = free_idx[4:0];
        end
        else begin
            v.status = ST_FULL;
        end
        return v;
    endfunction

    function automatic hdr_t make_hdr(input logic [3:0] ver, input logic [7:0] proto,
                                      input logic ok, input logic syn, input logic ack,
                                      input logic [31:0] addr, input logic [15:0] port);
        hdr_t h;
        h.version = ver;
        h.proto   = proto;
        h.hdr_ok  = ok;
        h.syn     = syn;
        h.ack     = ack;
        h.addr    = addr;
        h.port    = port;
        return h;
    endfunction

    function automatic dir_row_t as_typed(input hdr_t h, input logic nc,
                                          input logic [2:0] st, input logic [4:0] sl);
        dir_row_t r;
        r.hdr              = h;
        r.typed            = 1'b1;
        r.verdict.new_conn = nc;
        r.verdict.status   = st;
        r.verdict.slot     = sl;
        return r;
    endfunction

    function automatic dir_row_t as_predicted(input hdr_t h);
        dir_row_t r;
        r.hdr     = h;
        r.typed   = 1'b0;
        r.verdict = '0;
        return r;
    endfunction

    // Present one request, hold it until taken, and record its verdict
    task automatic send_header(input hdr_t h, input logic typed, input verdict_t fixed_v);
        verdict_t v;
        while (!steady && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, h};
        do
            @(posedge clk);
        while (!s_tready);
        v = classify_syn(h);
        verdict_q.push_back(typed ? fixed_v : v);
        n_reqs++;
        @(negedge clk);
    endtask

    // Randomize the result-side backpressure
    always @(negedge clk)
        m_tready <= steady || ($urandom_range(99) >= 25);

    // Compare each accepted result with the oldest pending verdict
    always @(posedge clk) begin
        verdict_t got;
        verdict_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata[8:0];
            n_results++;
            case (got.status)
                ST_NEW:  n_new++;
                ST_SEEN: n_seen++;
                ST_FULL: n_full++;
                default: n_filtered++;
            endcase
            if (verdict_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result new=%0b status=%0d slot=%0d",
                         $time, got.new_conn, got.status, got.slot);
            end
            else begin
                want = verdict_q.pop_front();
                if (got.new_conn !== want.new_conn) begin
                    n_errors++;
                    $display("%0t: new_connection expected %0b actual %0b",
                             $time, want.new_conn, got.new_conn);
                end
                if (got.status !== want.status) begin
                    n_errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                end
                if (got.slot !== want.slot) begin
                    n_errors++;
                    $display("%0t: slot expected %0d actual %0d",
                             $time, want.slot, got.slot);
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        hdr_t h;
        int   kind;
        int   defect;
        int   pick;
        int   v;

        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            pair_valid[i] = 1'b0;
            pair_addr[i]  = '0;
            pair_port[i]  = '0;
        end

        // Filter rules, field extremes, first stores and first matches
        dir_rows.push_back(as_typed(make_hdr(4'd0, 8'd0, 0, 0, 0, 32'h0, 16'h0),
                                    1'b0, ST_NOT_TCP, 5'd0));
        dir_rows.push_back(as_typed(make_hdr(4'hF, 8'hFF, 1, 1, 0, 32'hFFFF_FFFF, 16'hFFFF),
                                    1'b0, ST_NOT_TCP, 5'd0));
        // unreadable TCP header on an otherwise pure SYN
        dir_rows.push_back(as_typed(make_hdr(IPV4_VERSION, PROTO_TCP, 0, 1, 0, 32'h1, 16'h1),
                                    1'b0, ST_NOT_TCP, 5'd0));
        dir_rows.push_back(as_predicted(make_hdr(IPV4_VERSION, 8'd7, 1, 1, 0, 32'h2, 16'h2)));
        dir_rows.push_back(as_predicted(make_hdr(4'd6, PROTO_TCP, 1, 1, 0, 32'h3, 16'h3)));
        dir_rows.push_back(as_typed(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 0, 0, 32'h0, 16'h0),
                                    1'b0, ST_NOT_SYN, 5'd0));
        dir_rows.push_back(as_typed(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 1, 32'h0, 16'h0),
                                    1'b0, ST_NOT_SYN, 5'd0));
        dir_rows.push_back(as_predicted(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 0, 1,
                                                 32'hFFFF_FFFF, 16'hFFFF)));
        // empty table: lowest free slot is zero
        dir_rows.push_back(as_typed(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 0, 32'h0, 16'h0),
                                    1'b1, ST_NEW, 5'd0));
        dir_rows.push_back(as_typed(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 0,
                                             32'hFFFF_FFFF, 16'hFFFF),
                                    1'b1, ST_NEW, 5'd1));
        // match wins over the free slots behind it
        dir_rows.push_back(as_typed(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 0, 32'h0, 16'h0),
                                    1'b0, ST_SEEN, 5'd0));
        dir_rows.push_back(as_predicted(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 0,
                                                 32'h0, 16'hFFFF)));
        dir_rows.push_back(as_predicted(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 0,
                                                 32'hFFFF_FFFF, 16'h0)));
        dir_rows.push_back(as_predicted(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 0,
                                                 32'hFFFF_FFFF, 16'hFFFF)));
        dir_rows.push_back(as_predicted(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 1,
                                                 32'hFFFF_FFFF, 16'hFFFF)));
        dir_rows.push_back(as_predicted(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 0,
                                                 32'hA5A5_A5A5, 16'h5A5A)));
        dir_rows.push_back(as_predicted(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 0,
                                                 32'h5A5A_5A5A, 16'hA5A5)));
        dir_rows.push_back(as_predicted(make_hdr(IPV4_VERSION, PROTO_TCP, 0, 1, 0,
                                                 32'hA5A5_A5A5, 16'h5A5A)));
        dir_rows.push_back(as_predicted(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 0,
                                                 32'hA5A5_A5A5, 16'h5A5A)));
        // same address, neighboring port: a distinct pair
        dir_rows.push_back(as_predicted(make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 0,
                                                 32'hA5A5_A5A5, 16'h5A5B)));

        // Hold reset, then release on a falling edge
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (dir_rows[i])
            send_header(dir_rows[i].hdr, dir_rows[i].typed, dir_rows[i].verdict);

        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, 16'($urandom_range(65535))};

        // Random traffic: mostly pure SYNs from the pool, some near misses and noise
        for (int n = 0; n < RANDOM_REQS; n++) begin
            steady <= (n >= 250 && n < 400);
            kind = $urandom_range(99);
            pick = $urandom_range(POOL_SIZE - 1);
            h = make_hdr(IPV4_VERSION, PROTO_TCP, 1, 1, 0,
                         key_pool[pick][47:16], key_pool[pick][15:0]);
            if (kind < 15) begin
                h = hdr_t'({$urandom_range(1 << 30), $urandom, $urandom});
            end
            else if (kind < 30) begin
                defect = $urandom_range(5);
                case (defect)
                    0: h.hdr_ok = 1'b0;
                    1: h.syn = 1'b0;
                    2: h.ack = 1'b1;
                    3: begin
                        h.syn = 1'b0;
                        h.ack = 1'b1;
                    end
                    4: begin
                        v = $urandom_range(14);
                        h.version = (v >= IPV4_VERSION) ? 4'(v + 1) : 4'(v);
                    end
                    default: begin
                        v = $urandom_range(254);
                        h.proto = (v >= PROTO_TCP) ? 8'(v + 1) : 8'(v);
                    end
                endcase
            end
            else if (kind < 38) begin
                h.addr = $urandom;
                h.port = 16'($urandom_range(65535));
            end
            send_header(h, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        steady   <= 1'b0;

        // Drain, then watch for stray results
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (TABLE_ENTRIES + 8) @(posedge clk);

        $display("Sent %0d requests, checked %0d results with %0d mismatches.",
                 n_reqs, n_results, n_errors);
        $display("Verdicts: %0d new pairs, %0d repeats, %0d table full, %0d filtered.",
                 n_new, n_seen, n_full, n_filtered);
        if (n_errors == 0 && verdict_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Stop a hung run
    initial begin
        #400_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
